// ----- hdl/fmp_pkg.sv -----
// ----------------------------------------------------------------------------
// Framed message parser package
// Shared types, constants and the CRC-16 byte update for the parser.
// ----------------------------------------------------------------------------
package fmp_pkg;

    localparam int MAX_MESSAGES_DEF = 16;

    localparam logic [7:0]  SOF_BYTE_RESET    = 8'hAA;
    localparam logic [15:0] CRC_INITIAL_RESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'h1021;

    localparam logic [7:0] REG_SOF_BYTE    = 8'd0;
    localparam logic [7:0] REG_CRC_INITIAL = 8'd1;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_PAYLOAD    = 3'd1,
        EV_MSG_DONE   = 3'd2,
        EV_FRAME_OK   = 3'd3,
        EV_FRAME_OVER = 3'd4,
        EV_CRC_ERR    = 3'd5,
        EV_LEN_ERR    = 3'd6
    } event_t;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  data_byte;
        logic [7:0]  payload_index;
        logic [7:0]  msg_type;
        logic [7:0]  msg_seq;
        logic [7:0]  msg_status;
        logic [7:0]  msg_len;
        logic [4:0]  messages_done;
        logic        pending_present;
        logic [15:0] length_errors;
        logic [15:0] crc_errors;
        logic [15:0] overwrites;
    } result_t;

    typedef struct packed {
        logic [7:0]  index;
        logic [15:0] data;
    } cfg_word_t;

    typedef struct packed {
        logic [7:0]  sof_byte;
        logic [15:0] crc_initial;
    } cfg_regs_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            v = v[15] ? ({v[14:0], 1'b0} ^ CRC_POLY) : {v[14:0], 1'b0};
        end
        return v;
    endfunction

endpackage

// ----- hdl/fmp_stream_if.sv -----
// ----------------------------------------------------------------------------
// Framed message parser stream interface
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface fmp_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/framed_message_parser_crc16_top.sv -----
// Results are registered: a word passes the input register, then the result
// register. Throughput: one word per cycle while results are not held back;
// the byte-wide CRC update and the frame and message state step complete between them.
// Reset: asynchronous, active low; clears all parser state, the counters and
// the pending mark, and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// Framed message parser with CRC-16 check
// Top level joining the config registers, input register and parser core.
// ----------------------------------------------------------------------------
module framed_message_parser_crc16_top #(
    parameter int MAX_MESSAGES = fmp_pkg::MAX_MESSAGES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    fmp_stream_if.sink   item,
    fmp_stream_if.source result,
    fmp_stream_if.sink   cfg
);
    import fmp_pkg::*;

    cfg_regs_t regs;
    stage_t    stage;
    logic      take;

    fmp_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    fmp_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .take  (take),
        .stage (stage)
    );

    fmp_parser #(
        .MAX_MESSAGES (MAX_MESSAGES)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .stage  (stage),
        .regs   (regs),
        .take   (take),
        .result (result)
    );
endmodule

// ----- hdl/fmp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Framed message parser configuration registers
// Holds the start byte and the CRC initial value written over the config port.
// ----------------------------------------------------------------------------
module fmp_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    fmp_stream_if.sink         cfg,
    output fmp_pkg::cfg_regs_t regs
);
    import fmp_pkg::*;

    cfg_regs_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.sof_byte    <= SOF_BYTE_RESET;
            regs_reg.crc_initial <= CRC_INITIAL_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.payload.index == REG_SOF_BYTE)
            begin
                regs_reg.sof_byte <= cfg.payload.data[7:0];
            end
            else if (cfg.payload.index == REG_CRC_INITIAL)
            begin
                regs_reg.crc_initial <= cfg.payload.data;
            end
        end
    end
endmodule

// ----- hdl/fmp_in_stage.sv -----
// ----------------------------------------------------------------------------
// Framed message parser input register
// Registers one input word and releases it when the parser takes it.
// ----------------------------------------------------------------------------
module fmp_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    fmp_stream_if.sink      item,
    input  logic            take,
    output fmp_pkg::stage_t stage
);
    import fmp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign item.ready  = !valid_reg || take;
    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            item_reg <= item.payload;
        end
    end
endmodule

// ----- hdl/fmp_parser.sv -----
// ----------------------------------------------------------------------------
// Framed message parser core
// Frame and message state, CRC check, counters and the result register.
// ----------------------------------------------------------------------------
module fmp_parser #(
    parameter int MAX_MESSAGES = fmp_pkg::MAX_MESSAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fmp_pkg::stage_t    stage,
    input  fmp_pkg::cfg_regs_t regs,
    output logic               take,
    fmp_stream_if.source       result
);
    import fmp_pkg::*;

    localparam int MSG_W = $clog2(MAX_MESSAGES + 1);

    typedef enum logic [2:0] {
        PH_IDLE, PH_LEN_LO, PH_LEN_HI, PH_COUNT, PH_MSGS, PH_CRC_LO, PH_CRC_HI
    } frame_t;

    typedef enum logic [2:0] {
        MP_TYPE, MP_SEQ, MP_STATUS, MP_LEN, MP_PAYLOAD
    } msg_t;

    frame_t             phase_reg, phase_next;
    msg_t               mphase_reg, mphase_next;
    logic [15:0]        crc_reg, crc_next, crc_upd;
    logic [7:0]         crc_lo_reg, crc_lo_next;
    logic [15:0]        exp_len_reg, exp_len_next;
    logic [16:0]        seen_reg, seen_next;
    logic [MSG_W-1:0]   total_reg, total_next;
    logic [MSG_W-1:0]   count_reg, count_next;
    logic [7:0]         type_reg, type_next;
    logic [7:0]         seq_reg, seq_next;
    logic [7:0]         status_reg, status_next;
    logic [7:0]         len_reg, len_next;
    logic [7:0]         pos_reg, pos_next, pos_inc;
    logic               pending_reg, pending_next;
    logic [15:0]        len_err_reg, len_err_next;
    logic [15:0]        crc_err_reg, crc_err_next;
    logic [15:0]        over_reg, over_next;
    logic               res_valid_reg;
    result_t            res_reg, res_next;
    event_t             ev;
    logic [7:0]         b;
    logic [7:0]         pidx;
    logic               done;
    logic               step;

    assign take           = !res_valid_reg || result.ready;
    assign step           = stage.valid && take;
    assign result.valid   = res_valid_reg;
    assign result.payload = res_reg;
    assign b              = stage.item.rx_byte;
    assign crc_upd        = crc_byte(crc_reg, b);
    assign pos_inc        = pos_reg + 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        mphase_next  = mphase_reg;
        crc_next     = crc_reg;
        crc_lo_next  = crc_lo_reg;
        exp_len_next = exp_len_reg;
        seen_next    = seen_reg;
        total_next   = total_reg;
        count_next   = count_reg;
        type_next    = type_reg;
        seq_next     = seq_reg;
        status_next  = status_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        pending_next = pending_reg;
        len_err_next = len_err_reg;
        crc_err_next = crc_err_reg;
        over_next    = over_reg;
        ev           = EV_NONE;
        pidx         = 8'd0;
        done         = 1'b0;

        if (stage.item.func)
        begin
            pending_next = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (b == regs.sof_byte)
                    begin
                        mphase_next = MP_TYPE;
                        crc_next    = regs.crc_initial;
                        crc_lo_next = 8'd0;
                        seen_next   = '0;
                        total_next  = '0;
                        count_next  = '0;
                        type_next   = 8'd0;
                        seq_next    = 8'd0;
                        status_next = 8'd0;
                        len_next    = 8'd0;
                        pos_next    = 8'd0;
                        phase_next  = PH_LEN_LO;
                    end
                end
                PH_LEN_LO:
                begin
                    crc_next     = crc_upd;
                    exp_len_next = {8'd0, b};
                    phase_next   = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    crc_next     = crc_upd;
                    exp_len_next = {b, exp_len_reg[7:0]};
                    phase_next   = PH_COUNT;
                end
                PH_COUNT:
                begin
                    crc_next = crc_upd;
                    if (b > 8'(MAX_MESSAGES))
                    begin
                        len_err_next = len_err_reg + 16'd1;
                        ev           = EV_LEN_ERR;
                        phase_next   = PH_IDLE;
                    end
                    else
                    begin
                        total_next = MSG_W'(b);
                        phase_next = (b != 8'd0) ? PH_MSGS : PH_CRC_LO;
                    end
                end
                PH_MSGS:
                begin
                    crc_next  = crc_upd;
                    seen_next = seen_reg + 17'd1;
                    case (mphase_reg)
                        MP_TYPE:
                        begin
                            type_next   = b;
                            seq_next    = 8'd0;
                            status_next = 8'd0;
                            len_next    = 8'd0;
                            pos_next    = 8'd0;
                            mphase_next = MP_SEQ;
                        end
                        MP_SEQ:
                        begin
                            seq_next    = b;
                            mphase_next = MP_STATUS;
                        end
                        MP_STATUS:
                        begin
                            status_next = b;
                            mphase_next = MP_LEN;
                        end
                        MP_LEN:
                        begin
                            len_next = b;
                            pos_next = 8'd0;
                            if (b != 8'd0)
                            begin
                                mphase_next = MP_PAYLOAD;
                            end
                            else
                            begin
                                mphase_next = MP_TYPE;
                                done        = 1'b1;
                            end
                        end
                        default:
                        begin
                            ev       = EV_PAYLOAD;
                            pidx     = pos_reg;
                            pos_next = pos_inc;
                            if (pos_inc >= len_reg)
                            begin
                                mphase_next = MP_TYPE;
                                done        = 1'b1;
                            end
                        end
                    endcase
                    if (done)
                    begin
                        count_next = count_reg + MSG_W'(1);
                        ev         = EV_MSG_DONE;
                    end
                    if (count_next == total_reg)
                    begin
                        if (seen_next == {1'b0, exp_len_reg})
                        begin
                            phase_next = PH_CRC_LO;
                        end
                        else
                        begin
                            len_err_next = len_err_reg + 16'd1;
                            ev           = EV_LEN_ERR;
                            phase_next   = PH_IDLE;
                        end
                    end
                    else if (seen_next > {1'b0, exp_len_reg})
                    begin
                        len_err_next = len_err_reg + 16'd1;
                        ev           = EV_LEN_ERR;
                        phase_next   = PH_IDLE;
                    end
                end
                PH_CRC_LO:
                begin
                    crc_lo_next = b;
                    phase_next  = PH_CRC_HI;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if ({b, crc_lo_reg} != crc_reg)
                    begin
                        crc_err_next = crc_err_reg + 16'd1;
                        ev           = EV_CRC_ERR;
                    end
                    else if (pending_reg)
                    begin
                        over_next = over_reg + 16'd1;
                        ev        = EV_FRAME_OVER;
                    end
                    else
                    begin
                        pending_next = 1'b1;
                        ev           = EV_FRAME_OK;
                    end
                end
            endcase
        end

        res_next.event_res       = ev;
        res_next.data_byte       = stage.item.func ? 8'd0 : b;
        res_next.payload_index   = pidx;
        res_next.msg_type        = type_next;
        res_next.msg_seq         = seq_next;
        res_next.msg_status      = status_next;
        res_next.msg_len         = len_next;
        res_next.messages_done   = 5'(count_next);
        res_next.pending_present = pending_next;
        res_next.length_errors   = len_err_next;
        res_next.crc_errors      = crc_err_next;
        res_next.overwrites      = over_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            mphase_reg    <= MP_TYPE;
            crc_reg       <= CRC_INITIAL_RESET;
            crc_lo_reg    <= 8'd0;
            exp_len_reg   <= 16'd0;
            seen_reg      <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            type_reg      <= 8'd0;
            seq_reg       <= 8'd0;
            status_reg    <= 8'd0;
            len_reg       <= 8'd0;
            pos_reg       <= 8'd0;
            pending_reg   <= 1'b0;
            len_err_reg   <= 16'd0;
            crc_err_reg   <= 16'd0;
            over_reg      <= 16'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                res_valid_reg <= stage.valid;
            end
            if (step)
            begin
                phase_reg   <= phase_next;
                mphase_reg  <= mphase_next;
                crc_reg     <= crc_next;
                crc_lo_reg  <= crc_lo_next;
                exp_len_reg <= exp_len_next;
                seen_reg    <= seen_next;
                total_reg   <= total_next;
                count_reg   <= count_next;
                type_reg    <= type_next;
                seq_reg     <= seq_next;
                status_reg  <= status_next;
                len_reg     <= len_next;
                pos_reg     <= pos_next;
                pending_reg <= pending_next;
                len_err_reg <= len_err_next;
                crc_err_reg <= crc_err_next;
                over_reg    <= over_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

`ifndef ASSERT_OFF
    a_pending_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pending_reg) |-> (res_reg.event_res == EV_FRAME_OK))
        else $error("pending mark set without a verified frame");

    a_crc_err_count: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(crc_err_reg) |-> (res_reg.event_res == EV_CRC_ERR))
        else $error("CRC error counter moved without a CRC error event");

    a_overwrite_count: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(over_reg) |-> (res_reg.event_res == EV_FRAME_OVER && pending_reg))
        else $error("overwrite counter moved without an overwrite event");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MSGS) |-> (count_reg < total_reg))
        else $error("message count reached the total while still in messages");
`endif
endmodule

// ----- dv/tb_framed_message_parser_crc16_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the framed message parser with CRC-16 check
// Drives byte words and clear requests through the item channel, writes the
// start byte and CRC seed registers between phases, and compares every result
// word with an in-bench parser model under random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_framed_message_parser_crc16_top;

    import fmp_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int MSG_LIMIT   = MAX_MESSAGES_DEF;
    localparam int CYCLE_LIMIT = 600000;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_LEN_LO,
        FR_LEN_HI,
        FR_COUNT,
        FR_MSGS,
        FR_CRC_LO,
        FR_CRC_HI
    } frame_phase_t;

    typedef enum logic [2:0] {
        MS_TYPE,
        MS_SEQ,
        MS_STATUS,
        MS_LEN,
        MS_PAYLOAD
    } msg_phase_t;

    typedef enum {
        FLAW_NONE,
        FLAW_CRC,
        FLAW_LEN_SHORT,
        FLAW_LEN_LONG,
        FLAW_COUNT
    } frame_flaw_t;

    logic clk = 1'b0;
    logic rst_n;

    fmp_stream_if #(.payload_t(item_t))     item_if();
    fmp_stream_if #(.payload_t(result_t))   result_if();
    fmp_stream_if #(.payload_t(cfg_word_t)) cfg_if();

    framed_message_parser_crc16_top #(
        .MAX_MESSAGES(MSG_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_if),
        .result(result_if),
        .cfg(cfg_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    logic [7:0]   sh_sof_byte   = SOF_BYTE_RESET;
    logic [15:0]  sh_crc_init   = CRC_INITIAL_RESET;

    frame_phase_t fr_phase   = FR_IDLE;
    msg_phase_t   ms_phase   = MS_TYPE;
    logic [15:0]  crc_run    = CRC_INITIAL_RESET;
    logic [7:0]   crc_lo_rx  = 8'h00;
    logic [15:0]  len_stated = 16'h0000;
    int unsigned  bytes_cnt  = 0;
    logic [4:0]   msg_total  = 5'd0;
    logic [4:0]   msg_done   = 5'd0;
    logic [7:0]   hdr_fields [4] = '{default: 8'h00};
    logic [7:0]   pay_pos    = 8'h00;
    logic         pend       = 1'b0;
    logic [15:0]  len_errs   = 16'h0000;
    logic [15:0]  crc_errs   = 16'h0000;
    logic [15:0]  over_cnt   = 16'h0000;

    result_t      parser_outputs_due [$];
    logic [7:0]   frame_bytes [$];

    int           mismatches  = 0;
    int           words_parsed = 0;
    bit           idling_on   = 1'b1;
    int           sender_odds = 3;
    int           hold_cycles = 0;

    function automatic logic [15:0] crc16_update(logic [15:0] acc, logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    function automatic result_t parse_word(item_t w);
        result_t    r;
        event_t     ev;
        logic [7:0] b;
        logic [7:0] pidx;
        logic       is_pay;
        logic       done;
        ev     = EV_NONE;
        b      = w.rx_byte;
        pidx   = 8'h00;
        is_pay = 1'b0;
        done   = 1'b0;
        if (w.func)
        begin
            pend = 1'b0;
        end
        else
        begin
            case (fr_phase)
                FR_IDLE:
                begin
                    if (b == sh_sof_byte)
                    begin
                        ms_phase  = MS_TYPE;
                        crc_run   = sh_crc_init;
                        crc_lo_rx = 8'h00;
                        bytes_cnt = 0;
                        msg_total = 5'd0;
                        msg_done  = 5'd0;
                        foreach (hdr_fields[i])
                            hdr_fields[i] = 8'h00;
                        pay_pos   = 8'h00;
                        fr_phase  = FR_LEN_LO;
                    end
                end
                FR_LEN_LO:
                begin
                    crc_run    = crc16_update(crc_run, b);
                    len_stated = {8'h00, b};
                    fr_phase   = FR_LEN_HI;
                end
                FR_LEN_HI:
                begin
                    crc_run          = crc16_update(crc_run, b);
                    len_stated[15:8] = b;
                    fr_phase         = FR_COUNT;
                end
                FR_COUNT:
                begin
                    crc_run = crc16_update(crc_run, b);
                    if (b > MSG_LIMIT)
                    begin
                        len_errs = len_errs + 16'd1;
                        ev       = EV_LEN_ERR;
                        fr_phase = FR_IDLE;
                    end
                    else
                    begin
                        msg_total = b[4:0];
                        fr_phase  = (b != 8'h00) ? FR_MSGS : FR_CRC_LO;
                    end
                end
                FR_MSGS:
                begin
                    crc_run   = crc16_update(crc_run, b);
                    bytes_cnt = bytes_cnt + 1;
                    case (ms_phase)
                        MS_TYPE:
                        begin
                            foreach (hdr_fields[i])
                                hdr_fields[i] = 8'h00;
                            pay_pos       = 8'h00;
                            hdr_fields[0] = b;
                            ms_phase      = MS_SEQ;
                        end
                        MS_SEQ:
                        begin
                            hdr_fields[1] = b;
                            ms_phase      = MS_STATUS;
                        end
                        MS_STATUS:
                        begin
                            hdr_fields[2] = b;
                            ms_phase      = MS_LEN;
                        end
                        MS_LEN:
                        begin
                            hdr_fields[3] = b;
                            pay_pos       = 8'h00;
                            if (b != 8'h00)
                            begin
                                ms_phase = MS_PAYLOAD;
                            end
                            else
                            begin
                                ms_phase = MS_TYPE;
                                done     = 1'b1;
                            end
                        end
                        default:
                        begin
                            is_pay  = 1'b1;
                            pidx    = pay_pos;
                            pay_pos = pay_pos + 8'd1;
                            if (pay_pos >= hdr_fields[3])
                            begin
                                ms_phase = MS_TYPE;
                                done     = 1'b1;
                            end
                        end
                    endcase
                    if (done)
                        msg_done = msg_done + 5'd1;
                    if (is_pay)
                        ev = EV_PAYLOAD;
                    if (done)
                        ev = EV_MSG_DONE;
                    if (msg_done == msg_total)
                    begin
                        if (bytes_cnt == len_stated)
                        begin
                            fr_phase = FR_CRC_LO;
                        end
                        else
                        begin
                            len_errs = len_errs + 16'd1;
                            ev       = EV_LEN_ERR;
                            fr_phase = FR_IDLE;
                        end
                    end
                    else if (bytes_cnt > len_stated)
                    begin
                        len_errs = len_errs + 16'd1;
                        ev       = EV_LEN_ERR;
                        fr_phase = FR_IDLE;
                    end
                end
                FR_CRC_LO:
                begin
                    crc_lo_rx = b;
                    fr_phase  = FR_CRC_HI;
                end
                default:
                begin
                    fr_phase = FR_IDLE;
                    if ({b, crc_lo_rx} != crc_run)
                    begin
                        crc_errs = crc_errs + 16'd1;
                        ev       = EV_CRC_ERR;
                    end
                    else if (pend)
                    begin
                        over_cnt = over_cnt + 16'd1;
                        ev       = EV_FRAME_OVER;
                    end
                    else
                    begin
                        pend = 1'b1;
                        ev   = EV_FRAME_OK;
                    end
                end
            endcase
        end
        r.event_res       = ev;
        r.data_byte       = w.func ? 8'h00 : b;
        r.payload_index   = pidx;
        r.msg_type        = hdr_fields[0];
        r.msg_seq         = hdr_fields[1];
        r.msg_status      = hdr_fields[2];
        r.msg_len         = hdr_fields[3];
        r.messages_done   = msg_done;
        r.pending_present = pend;
        r.length_errors   = len_errs;
        r.crc_errors      = crc_errs;
        r.overwrites      = over_cnt;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < 100)
            $display("%0t ERROR %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    task automatic send_word(logic func, logic [7:0] b);
        item_t w;
        int    gap;
        w.func    = func;
        w.rx_byte = b;
        if (func || fr_phase != FR_IDLE || b == sh_sof_byte)
            words_parsed++;
        @(negedge clk);
        item_if.valid   <= 1'b1;
        item_if.payload <= w;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        parser_outputs_due = {parser_outputs_due, parse_word(w)};
        if (sender_odds != 0 && $urandom_range(1, sender_odds) == 1)
        begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            item_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        item_if.valid <= 1'b0;
        while (parser_outputs_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] reg_index, logic [15:0] data);
        cfg_word_t wr;
        wr.index = reg_index;
        wr.data  = data;
        @(negedge clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= wr;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (reg_index == REG_SOF_BYTE)
            sh_sof_byte = data[7:0];
        else if (reg_index == REG_CRC_INITIAL)
            sh_crc_init = data;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic build_frame(int n_msgs, int pay_max, frame_flaw_t flaw);
        logic [7:0]  body [$];
        logic [15:0] span;
        logic [15:0] crc;
        logic [7:0]  cnt;
        int          plen;
        int          pick;
        body = {};
        for (int m = 0; m < n_msgs; m++)
        begin
            body = {body, ($urandom_range(0, 3) == 0) ? sh_sof_byte : 8'($urandom)};
            body = {body, 8'($urandom)};
            body = {body, 8'($urandom)};
            pick = $urandom_range(0, 19);
            if (pick == 0)
                plen = pay_max;
            else if (pick < 3)
                plen = $urandom_range(0, pay_max);
            else
                plen = $urandom_range(0, (pay_max < 4) ? pay_max : 4);
            body = {body, 8'(plen)};
            repeat (plen) body = {body, 8'($urandom)};
        end
        span = 16'(body.size());
        cnt  = 8'(n_msgs);
        case (flaw)
            FLAW_LEN_SHORT:
                if (span != 16'h0000)
                    span = span - 16'($urandom_range(1, span));
            FLAW_LEN_LONG:
                if ($urandom_range(0, 3) == 0)
                    span = 16'($urandom_range(span + 1, 65535));
                else
                    span = span + 16'($urandom_range(1, 3));
            FLAW_COUNT:
                cnt = ($urandom_range(0, 1) == 0) ? 8'(MSG_LIMIT + 1)
                                                   : 8'($urandom_range(MSG_LIMIT + 1, 255));
            default:
                ;
        endcase
        crc = crc16_update(sh_crc_init, span[7:0]);
        crc = crc16_update(crc, span[15:8]);
        crc = crc16_update(crc, cnt);
        foreach (body[i])
            crc = crc16_update(crc, body[i]);
        if (flaw == FLAW_CRC)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        frame_bytes = {sh_sof_byte, span[7:0], span[15:8], cnt};
        foreach (body[i])
            frame_bytes = {frame_bytes, body[i]};
        frame_bytes = {frame_bytes, crc[7:0], crc[15:8]};
    endtask

    // Stops early once the parser has dropped back to idle on an error.
    task automatic send_frame(int from, int upto, bit with_clears);
        for (int i = from; i < upto; i++)
        begin
            if (with_clears && $urandom_range(0, 29) == 0)
                send_word(1'b1, 8'($urandom));
            send_word(1'b0, frame_bytes[i]);
            if (fr_phase == FR_IDLE)
                break;
        end
    endtask

    // Drives the parser back to idle by the shortest way the frame format allows.
    task automatic settle_parser();
        logic [7:0] b;
        while (fr_phase != FR_IDLE)
        begin
            case (fr_phase)
                FR_COUNT:             b = 8'hFF;
                FR_CRC_LO, FR_CRC_HI: b = 8'($urandom);
                default:              b = 8'h00;
            endcase
            send_word(1'b0, b);
        end
    endtask

    task automatic run_frames(int n_words);
        int          target;
        int          n_msgs;
        int          pick;
        frame_flaw_t flaw;
        target = words_parsed + n_words;
        while (words_parsed < target)
        begin
            case ($urandom_range(0, 2))
                0:       sender_odds = 0;
                1:       sender_odds = 3;
                default: sender_odds = 8;
            endcase
            if (!idling_on)
                sender_odds = 0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_word(1'b0, 8'($urandom));
            settle_parser();
            pick = $urandom_range(0, 9);
            if (pick == 0)
                n_msgs = 0;
            else if (pick == 1)
                n_msgs = MSG_LIMIT;
            else
                n_msgs = $urandom_range(1, 5);
            pick = $urandom_range(0, 19);
            if (pick < 12)
                flaw = FLAW_NONE;
            else if (pick < 14)
                flaw = FLAW_CRC;
            else if (pick < 16)
                flaw = FLAW_LEN_SHORT;
            else if (pick < 18)
                flaw = FLAW_LEN_LONG;
            else
                flaw = FLAW_COUNT;
            build_frame(n_msgs, ($urandom_range(0, 9) == 0) ? 255 : 12, flaw);
            send_frame(0, frame_bytes.size(), 1'b1);
        end
    endtask

    task automatic test_idle_words();
        send_word(1'b1, 8'hFF);
        send_word(1'b0, ~sh_sof_byte);
    endtask

    task automatic test_short_frames();
        build_frame(1, 0, FLAW_NONE);
        send_frame(0, frame_bytes.size(), 1'b0);
        build_frame(0, 0, FLAW_NONE);
        send_frame(0, frame_bytes.size(), 1'b0);
        build_frame(0, 0, FLAW_CRC);
        send_frame(0, frame_bytes.size(), 1'b0);
    endtask

    task automatic test_count_limit();
        build_frame(0, 0, FLAW_COUNT);
        send_frame(0, frame_bytes.size(), 1'b0);
    endtask

    // A frame is split across each register change; its CRC must still use the
    // seed that was loaded when its start byte arrived.
    task automatic test_register_settings();
        logic [7:0]  starts [4];
        logic [15:0] inits [4];
        starts = '{8'h00, 8'hFF, 8'($urandom), SOF_BYTE_RESET};
        inits  = '{16'h0000, 16'hFFFF, 16'($urandom), CRC_INITIAL_RESET};
        for (int s = 0; s < 4; s++)
        begin
            settle_parser();
            build_frame(1, 4, FLAW_NONE);
            send_frame(0, 3, 1'b0);
            wait_for_results();
            write_reg(REG_SOF_BYTE, {8'h00, starts[s]});
            write_reg(REG_CRC_INITIAL, inits[s]);
            send_frame(3, frame_bytes.size(), 1'b0);
            run_frames(170);
        end
    endtask

    task automatic test_receiver_hold();
        wait_for_results();
        idling_on   = 1'b0;
        hold_cycles = 300;
        run_frames(120);
        idling_on   = 1'b1;
    endtask

    task automatic test_sender_pause();
        run_frames(100);
        wait_for_results();
        run_frames(100);
    endtask

    task automatic test_full_rate();
        idling_on = 1'b0;
        run_frames(250);
    endtask

    initial
    begin : result_sink
        int burst;
        int calm;
        burst = 0;
        calm  = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                result_if.ready <= 1'b0;
            end
            else if (!idling_on)
            begin
                burst = 0;
                result_if.ready <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                result_if.ready <= 1'b0;
            end
            else if (calm > 0)
            begin
                calm--;
                result_if.ready <= 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0:
                    begin
                        calm = $urandom_range(20, 200);
                        result_if.ready <= 1'b1;
                    end
                    1, 2, 3:
                    begin
                        burst = $urandom_range(1, 13) - 1;
                        result_if.ready <= 1'b0;
                    end
                    default:
                        result_if.ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t seen;
        result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            seen = result_if.payload;
            if (parser_outputs_due.size() == 0)
            begin
                report_mismatch($sformatf("result word with no expectation, event %0d",
                                          seen.event_res));
            end
            else
            begin
                want = parser_outputs_due.pop_front();
                check_field("event_res", seen.event_res, want.event_res);
                check_field("data_byte", seen.data_byte, want.data_byte);
                check_field("payload_index", seen.payload_index, want.payload_index);
                check_field("msg_type", seen.msg_type, want.msg_type);
                check_field("msg_seq", seen.msg_seq, want.msg_seq);
                check_field("msg_status", seen.msg_status, want.msg_status);
                check_field("msg_len", seen.msg_len, want.msg_len);
                check_field("messages_done", seen.messages_done, want.messages_done);
                check_field("pending_present", seen.pending_present, want.pending_present);
                check_field("length_errors", seen.length_errors, want.length_errors);
                check_field("crc_errors", seen.crc_errors, want.crc_errors);
                check_field("overwrites", seen.overwrites, want.overwrites);
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_framed_message_parser_crc16_top NOT OK");
        $finish;
    end

    initial
    begin
        item_if.valid   = 1'b0;
        item_if.payload = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.payload  = '0;
        rst_n           = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_words();
        test_short_frames();
        test_count_limit();
        run_frames(500);
        test_register_settings();
        test_receiver_hold();
        test_sender_pause();
        test_full_rate();

        wait_for_results();
        repeat (8) @(posedge clk);
        if (parser_outputs_due.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived",
                                      parser_outputs_due.size()));
        if (mismatches == 0)
            $display("tb_framed_message_parser_crc16_top OK");
        else
            $display("tb_framed_message_parser_crc16_top NOT OK");
        $finish;
    end

endmodule
